>>> src/glm_pkg.sv
// Shared constants and controller/datapath interface types for the glyph measure block.
`timescale 1ns / 1ps

package glm_pkg;

  localparam int GLM_TABLE_DEPTH = 256;

  localparam int CODE_W   = 21;
  localparam int HEIGHT_W = 12;
  localparam int METRIC_W = 16;
  localparam int MSUM_W   = 18;
  localparam int WIDTH_W  = 24;
  localparam int COUNT_W  = 9;
  localparam int INDEX_W  = 8;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_MEASURE = 1'b1;

  localparam logic signed [WIDTH_W:0] WIDTH_MAX = 25'sd8388607;
  localparam logic signed [WIDTH_W:0] WIDTH_MIN = -25'sd8388608;

  typedef struct packed {
    logic load;
    logic start;
    logic probe;
    logic cmp;
    logic acc;
    logic emit;
  } glm_cmd_t;

  typedef struct packed {
    logic more;
    logic hit;
    logic last;
    logic out_free;
  } glm_sts_t;

endpackage

>>> src/glyph_lookup_text_measure_top.sv
// Top level of the glyph table lookup and text width measurement block.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------------------
//   in      | input     | in_valid / in_ready | op, entry_index, char_code, glyph_height,
//           |           |                     | left_bearing, advance_width, right_bearing,
//           |           |                     | last
//   out     | output    | out_valid/out_ready | total_width, max_height, missing_glyph
//   cfg     | input     | cfg_valid/cfg_ready | cfg_data (entry_count)
//
// A load item is written to the table from the idle state. A measure item probes until its code
// is found or the bounds meet, with at most floor(log2(n)) + 1 probes for n searched entries;
// the hit or miss is accumulated in S_ACC, and a last item then emits the run's result.
// Each probe reads the table port in S_PROBE, then compares and moves the bounds in S_CMP.
// Reset clears the accumulators, entry_count and the output valid; the table is not cleared.
// A result waiting in the output register does not stop the next items; only the emit of
// the following run waits for out_ready.
`timescale 1ns / 1ps

module glyph_lookup_text_measure_top
  import glm_pkg::*;
#(
  parameter int TABLE_DEPTH = GLM_TABLE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       op,
  input  logic [INDEX_W-1:0]         entry_index,
  input  logic [CODE_W-1:0]          char_code,
  input  logic [HEIGHT_W-1:0]        glyph_height,
  input  logic signed [METRIC_W-1:0] left_bearing,
  input  logic signed [METRIC_W-1:0] advance_width,
  input  logic signed [METRIC_W-1:0] right_bearing,
  input  logic                       last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [WIDTH_W-1:0]  total_width,
  output logic [HEIGHT_W-1:0]        max_height,
  output logic                       missing_glyph,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [COUNT_W-1:0]         cfg_data
);

  glm_cmd_t cmd;
  glm_sts_t sts;

  assign cfg_ready = 1'b1;

  glm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_op    (op),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  glm_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .entry_index   (entry_index),
    .char_code     (char_code),
    .glyph_height  (glyph_height),
    .left_bearing  (left_bearing),
    .advance_width (advance_width),
    .right_bearing (right_bearing),
    .last          (last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .total_width   (total_width),
    .max_height    (max_height),
    .missing_glyph (missing_glyph)
  );

endmodule

>>> src/glm_datapath.sv
// Glyph table memory, binary search bounds, accumulators and output register.
`timescale 1ns / 1ps

module glm_datapath
  import glm_pkg::*;
#(
  parameter int TABLE_DEPTH = GLM_TABLE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  glm_cmd_t                   cmd,
  output glm_sts_t                   sts,
  input  logic                       cfg_valid,
  input  logic [COUNT_W-1:0]         cfg_data,
  input  logic [INDEX_W-1:0]         entry_index,
  input  logic [CODE_W-1:0]          char_code,
  input  logic [HEIGHT_W-1:0]        glyph_height,
  input  logic signed [METRIC_W-1:0] left_bearing,
  input  logic signed [METRIC_W-1:0] advance_width,
  input  logic signed [METRIC_W-1:0] right_bearing,
  input  logic                       last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [WIDTH_W-1:0]  total_width,
  output logic [HEIGHT_W-1:0]        max_height,
  output logic                       missing_glyph
);

  localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int MAXN = (TABLE_DEPTH < 511) ? TABLE_DEPTH : 511;
  localparam int BW   = $clog2(MAXN + 1);
  localparam int MW   = CODE_W + HEIGHT_W + MSUM_W;

  logic [MW-1:0] mem [TABLE_DEPTH];

  logic [COUNT_W-1:0]         entry_count;
  logic [CODE_W-1:0]          key;
  logic                       last_r;
  logic [BW-1:0]              lo;
  logic [BW-1:0]              hip;
  logic [BW-1:0]              mid;
  logic                       found;
  logic [MW-1:0]              rd_entry;
  logic signed [WIDTH_W-1:0]  width_sum;
  logic [HEIGHT_W-1:0]        height_max;
  logic                       miss_seen;

  logic [BW-1:0]              n_c;
  logic [BW-1:0]              mid_c;
  logic signed [MSUM_W-1:0]   msum_c;
  logic [CODE_W-1:0]          rd_code;
  logic [HEIGHT_W-1:0]        rd_height;
  logic signed [MSUM_W-1:0]   rd_sum;
  logic signed [WIDTH_W:0]    sum_c;
  logic signed [WIDTH_W-1:0]  sat_c;

  assign n_c = (32'(entry_count) > TABLE_DEPTH) ? BW'(MAXN) : BW'(entry_count);
  assign mid_c = lo + ((hip - lo - BW'(1)) >> 1);
  assign msum_c = MSUM_W'(left_bearing) + MSUM_W'(advance_width) + MSUM_W'(right_bearing);

  assign rd_code   = rd_entry[MW-1 -: CODE_W];
  assign rd_height = rd_entry[MSUM_W +: HEIGHT_W];
  assign rd_sum    = rd_entry[MSUM_W-1:0];

  assign sum_c = (WIDTH_W+1)'(width_sum) + (WIDTH_W+1)'(rd_sum);

  always_comb begin
    if (sum_c > WIDTH_MAX) begin
      sat_c = WIDTH_MAX[WIDTH_W-1:0];
    end else if (sum_c < WIDTH_MIN) begin
      sat_c = WIDTH_MIN[WIDTH_W-1:0];
    end else begin
      sat_c = sum_c[WIDTH_W-1:0];
    end
  end

  assign sts.more     = lo < hip;
  assign sts.hit      = rd_code == key;
  assign sts.last     = last_r;
  assign sts.out_free = !out_valid || out_ready;

  // Store the code, height and metric sum; a probe reads the whole entry back.
  always_ff @(posedge clk) begin
    if (cmd.load && (32'(entry_index) < TABLE_DEPTH)) begin
      mem[AW'(entry_index)] <= {char_code, glyph_height, msum_c};
    end
    if (cmd.probe && sts.more) begin
      rd_entry <= mem[AW'(mid_c)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key    <= char_code;
      last_r <= last;
      lo     <= '0;
      hip    <= n_c;
      found  <= 1'b0;
    end
    if (cmd.probe && sts.more) begin
      mid <= mid_c;
    end
    if (cmd.cmp) begin
      if (sts.hit) begin
        found <= 1'b1;
      end else if (rd_code < key) begin
        lo <= mid + BW'(1);
      end else begin
        hip <= mid;
      end
    end
    if (cmd.emit) begin
      total_width   <= width_sum;
      max_height    <= height_max;
      missing_glyph <= miss_seen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      width_sum   <= '0;
      height_max  <= '0;
      miss_seen   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        entry_count <= cfg_data;
      end
      if (cmd.acc) begin
        if (found) begin
          width_sum <= sat_c;
          if (rd_height > height_max) begin
            height_max <= rd_height;
          end
        end else begin
          miss_seen <= 1'b1;
        end
      end
      if (cmd.emit) begin
        width_sum  <= '0;
        height_max <= '0;
        miss_seen  <= 1'b0;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> src/glm_ctrl.sv
// Sequencer for table loads and the probe/compare loop of a character lookup.
`timescale 1ns / 1ps

module glm_ctrl
  import glm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_op,
  output logic     in_ready,
  input  glm_sts_t sts,
  output glm_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PROBE = 5'b00010,
    S_CMP   = 5'b00100,
    S_ACC   = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == OP_MEASURE) begin
            cmd.start  = 1'b1;
            state_next = S_PROBE;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      S_PROBE: begin
        cmd.probe  = 1'b1;
        state_next = sts.more ? S_CMP : S_ACC;
      end
      S_CMP: begin
        cmd.cmp    = 1'b1;
        state_next = sts.hit ? S_ACC : S_PROBE;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = sts.last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        // hold until the output register can take the result
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> src/glm_checker.sv
// Port-level assertions for the glyph measure block and their bind to the top level.
`timescale 1ns / 1ps

module glm_checker
  import glm_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       op,
  input logic [INDEX_W-1:0]         entry_index,
  input logic [CODE_W-1:0]          char_code,
  input logic [HEIGHT_W-1:0]        glyph_height,
  input logic signed [METRIC_W-1:0] left_bearing,
  input logic signed [METRIC_W-1:0] advance_width,
  input logic signed [METRIC_W-1:0] right_bearing,
  input logic                       last,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [WIDTH_W-1:0]  total_width,
  input logic [HEIGHT_W-1:0]        max_height,
  input logic                       missing_glyph
);

  // a measure item occupies the block, so ready drops right after it
  a_measure_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && op == OP_MEASURE) |=> !in_ready)
    else $error("ready stayed high after a measure item");

  // a load item finishes in its own cycle
  a_load_single: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && op == OP_LOAD) |=> in_ready)
    else $error("block stalled after a load item");

  a_reset_state: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("block not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(total_width) && $stable(max_height) && $stable(missing_glyph)))
    else $error("result changed before it was taken");

  // hold the waiting input item
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_ready) |=>
      (in_valid && $stable(op) && $stable(entry_index) && $stable(char_code) &&
       $stable(glyph_height) && $stable(left_bearing) && $stable(advance_width) &&
       $stable(right_bearing) && $stable(last)))
    else $error("input item changed before it was taken");

endmodule

bind glyph_lookup_text_measure_top glm_checker u_glm_checker (.*);

>>> tb/tb.sv
// Testbench for glyph_lookup_text_measure_top: directed and random table loads and measured runs.
`timescale 1ns / 1ps

module tb;
  import glm_pkg::*;

  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 40;
  localparam int CODE_TOP     = 1114111;
  localparam int CODE_ALL     = 2097151;

  typedef struct packed {
    logic                       op;
    logic [INDEX_W-1:0]         idx;
    logic [CODE_W-1:0]          code;
    logic [HEIGHT_W-1:0]        hgt;
    logic signed [METRIC_W-1:0] lb;
    logic signed [METRIC_W-1:0] aw;
    logic signed [METRIC_W-1:0] rb;
    logic                       last;
  } glyph_item_t;

  typedef struct packed {
    logic signed [WIDTH_W-1:0] width;
    logic [HEIGHT_W-1:0]       height;
    logic                      miss;
  } run_result_t;

  logic                       clk;
  logic                       rst           = 1'b1;
  logic                       in_valid      = 1'b0;
  logic                       in_ready;
  logic                       op            = OP_LOAD;
  logic [INDEX_W-1:0]         entry_index   = '0;
  logic [CODE_W-1:0]          char_code     = '0;
  logic [HEIGHT_W-1:0]        glyph_height  = '0;
  logic signed [METRIC_W-1:0] left_bearing  = '0;
  logic signed [METRIC_W-1:0] advance_width = '0;
  logic signed [METRIC_W-1:0] right_bearing = '0;
  logic                       last          = 1'b0;
  logic                       out_valid;
  logic                       out_ready     = 1'b0;
  logic signed [WIDTH_W-1:0]  total_width;
  logic [HEIGHT_W-1:0]        max_height;
  logic                       missing_glyph;
  logic                       cfg_valid     = 1'b0;
  logic                       cfg_ready;
  logic [COUNT_W-1:0]         cfg_data      = '0;

  // shadow of the glyph table and the run accumulators
  logic [CODE_W-1:0]          mirror_code   [GLM_TABLE_DEPTH];
  logic [HEIGHT_W-1:0]        mirror_height [GLM_TABLE_DEPTH];
  logic signed [METRIC_W-1:0] mirror_lb     [GLM_TABLE_DEPTH];
  logic signed [METRIC_W-1:0] mirror_aw     [GLM_TABLE_DEPTH];
  logic signed [METRIC_W-1:0] mirror_rb     [GLM_TABLE_DEPTH];
  int                         searched_count = 0;
  int                         run_width      = 0;
  logic [HEIGHT_W-1:0]        run_height     = '0;
  logic                       run_miss       = 1'b0;
  run_result_t                run_result_q[$];
  run_result_t                want;

  int err_cnt      = 0;
  int gap_pct      = 0;
  int stall_pct    = 0;
  int quiet_cycles = 0;

  glyph_lookup_text_measure_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .entry_index   (entry_index),
    .char_code     (char_code),
    .glyph_height  (glyph_height),
    .left_bearing  (left_bearing),
    .advance_width (advance_width),
    .right_bearing (right_bearing),
    .last          (last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .total_width   (total_width),
    .max_height    (max_height),
    .missing_glyph (missing_glyph),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= 40) begin
      $display("[%0t] MISMATCH: %s", $time, msg);
    end
  endtask

  // binary search over the searched prefix, same probe order as the hardware
  function automatic int find_glyph_slot(input logic [CODE_W-1:0] code);
    int lo, hi, mid, n;
    n  = (searched_count > GLM_TABLE_DEPTH) ? GLM_TABLE_DEPTH : searched_count;
    lo = 0;
    hi = n - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (mirror_code[mid] == code) return mid;
      if (mirror_code[mid] < code) lo = mid + 1;
      else hi = mid - 1;
    end
    return -1;
  endfunction

  function automatic void predict_run_result(input glyph_item_t it);
    int slot, acc, a, b, c;
    run_result_t r;
    if (it.op == OP_LOAD) begin
      mirror_code[it.idx]   = it.code;
      mirror_height[it.idx] = it.hgt;
      mirror_lb[it.idx]     = it.lb;
      mirror_aw[it.idx]     = it.aw;
      mirror_rb[it.idx]     = it.rb;
      return;
    end
    slot = find_glyph_slot(it.code);
    if (slot < 0) begin
      run_miss = 1'b1;
    end else begin
      a   = mirror_lb[slot];
      b   = mirror_aw[slot];
      c   = mirror_rb[slot];
      acc = run_width + a + b + c;
      if (acc > WIDTH_MAX) acc = WIDTH_MAX;
      if (acc < WIDTH_MIN) acc = WIDTH_MIN;
      run_width = acc;
      if (mirror_height[slot] > run_height) run_height = mirror_height[slot];
    end
    if (it.last) begin
      r.width  = run_width[WIDTH_W-1:0];
      r.height = run_height;
      r.miss   = run_miss;
      run_result_q.push_back(r);
      run_width  = 0;
      run_height = '0;
      run_miss   = 1'b0;
    end
  endfunction

  task automatic send_item(input glyph_item_t it);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    op            <= it.op;
    entry_index   <= it.idx;
    char_code     <= it.code;
    glyph_height  <= it.hgt;
    left_bearing  <= it.lb;
    advance_width <= it.aw;
    right_bearing <= it.rb;
    last          <= it.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_run_result(it);
  endtask

  task automatic send_load(input int slot, input int code, input int hgt,
                           input int lb, input int aw, input int rb, input bit lst);
    glyph_item_t it;
    it.op   = OP_LOAD;
    it.idx  = slot[INDEX_W-1:0];
    it.code = code[CODE_W-1:0];
    it.hgt  = hgt[HEIGHT_W-1:0];
    it.lb   = lb[METRIC_W-1:0];
    it.aw   = aw[METRIC_W-1:0];
    it.rb   = rb[METRIC_W-1:0];
    it.last = lst;
    send_item(it);
  endtask

  task automatic send_measure(input int code, input bit lst);
    glyph_item_t it;
    logic [31:0] noise;
    noise   = $urandom;
    // fields a measure item ignores carry random bits
    it.op   = OP_MEASURE;
    it.idx  = noise[INDEX_W-1:0];
    it.code = code[CODE_W-1:0];
    it.hgt  = noise[19:8];
    it.lb   = noise[15:0];
    it.aw   = noise[31:16];
    it.rb   = noise[23:8];
    it.last = lst;
    send_item(it);
  endtask

  // drop valid, let every expected run arrive, then cover a full search
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (run_result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_entry_count(input int cnt);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= cnt[COUNT_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    searched_count = cnt;
    cfg_valid <= 1'b0;
  endtask

  task automatic load_sorted_table(input int n);
    int step, code, k;
    step = (CODE_TOP - n) / n;
    code = $urandom_range(step);
    for (k = 0; k < n; k++) begin
      send_load(k, code, $urandom_range(4095), $urandom, $urandom, $urandom, $urandom_range(1));
      // an occasional repeat leaves duplicate codes in the table
      code += ($urandom_range(15) == 0) ? 0 : 1 + $urandom_range(step);
    end
  endtask

  task automatic test_empty_table();
    write_entry_count(0);
    send_measure(5, 1'b1);
    send_measure(0, 1'b0);
    send_measure(CODE_TOP, 1'b1);
  endtask

  task automatic test_table_extremes();
    send_load(0, 0, 0, -32768, -32768, -32768, 1'b1);
    send_load(1, 100, 4095, 32767, 32767, 32767, 1'b0);
    send_load(2, CODE_TOP, 2048, 1, -2, 5, 1'b0);
    send_load(255, CODE_ALL, 'hABC, 'h5555, 'hAAAA, 'h0F0F, 1'b1);
    write_entry_count(3);
    send_measure(0, 1'b0);
    send_measure(100, 1'b0);
    send_measure(CODE_TOP, 1'b1);
    send_measure(50, 1'b1);
    // a load inside a run leaves the accumulators alone
    send_measure(100, 1'b0);
    send_load(2, CODE_TOP, 7, 0, 16, 0, 1'b1);
    send_measure(CODE_TOP, 1'b1);
  endtask

  task automatic test_unsorted_and_duplicates();
    send_load(0, 9, 10, 16, 16, 16, 1'b0);
    send_load(1, 3, 20, 32, 0, -16, 1'b0);
    send_load(2, 7, 30, 1, 2, 3, 1'b0);
    send_load(3, 7, 40, 100, 100, 100, 1'b0);
    write_entry_count(4);
    send_measure(9, 1'b0);
    send_measure(7, 1'b0);
    send_measure(3, 1'b1);
    send_measure(7, 1'b1);
  endtask

  task automatic test_width_saturation();
    int k;
    send_load(0, 10, 1, 32767, 32767, 32767, 1'b0);
    send_load(1, 20, 2, -32768, -32768, -32768, 1'b0);
    write_entry_count(2);
    for (k = 0; k < 86; k++) send_measure(10, k == 85);
    // pin at the bottom, then climb back a little
    for (k = 0; k < 86; k++) send_measure(20, 1'b0);
    for (k = 0; k < 3; k++) send_measure(10, k == 2);
  endtask

  task automatic test_random_runs();
    int ph, n, cnt, nsrch, sent, rlen, k, code;
    for (ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 63; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 63; end
        default: begin gap_pct = 10; stall_pct = 10; end
      endcase
      // the first phase fills every slot, so any count is safe from then on
      n = (ph < 2 || $urandom_range(9) == 0) ? GLM_TABLE_DEPTH : $urandom_range(1, 40);
      load_sorted_table(n);
      if (ph == 0) cnt = 511;
      else if (ph == 1) cnt = GLM_TABLE_DEPTH;
      else if ($urandom_range(9) == 0) cnt = 0;
      else if ($urandom_range(6) == 0) cnt = $urandom_range(GLM_TABLE_DEPTH + 1, 511);
      else if ($urandom_range(6) == 0) cnt = $urandom_range(GLM_TABLE_DEPTH);
      else cnt = $urandom_range(n / 2, n);
      write_entry_count(cnt);
      nsrch = (cnt > GLM_TABLE_DEPTH) ? GLM_TABLE_DEPTH : cnt;
      sent = 0;
      while (sent < 60) begin
        rlen = ($urandom_range(3) == 0) ? 1 : $urandom_range(2, 10);
        for (k = 1; k <= rlen; k++) begin
          if ($urandom_range(9) == 0) begin
            send_load($urandom_range(255), $urandom_range(CODE_TOP), $urandom_range(4095),
                      $urandom, $urandom, $urandom, $urandom_range(1));
            sent++;
          end
          if (nsrch > 0 && $urandom_range(3) != 0) begin
            code = mirror_code[$urandom_range(nsrch - 1)];
          end else if (nsrch > 0 && $urandom_range(1) == 0) begin
            code = mirror_code[$urandom_range(nsrch - 1)] + 1;
          end else if ($urandom_range(1) == 0) begin
            code = $urandom_range(CODE_TOP);
          end else begin
            code = $urandom_range(CODE_ALL);
          end
          send_measure(code, k == rlen);
          sent++;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (run_result_q.size() == 0) begin
        report_mismatch("result with no run pending");
      end else begin
        want = run_result_q.pop_front();
        if (total_width !== want.width)
          report_mismatch($sformatf("total_width got %0d exp %0d", total_width, want.width));
        if (max_height !== want.height)
          report_mismatch($sformatf("max_height got %0d exp %0d", max_height, want.height));
        if (missing_glyph !== want.miss)
          report_mismatch($sformatf("missing_glyph got %0b exp %0b", missing_glyph, want.miss));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_table_extremes();
    test_unsorted_and_duplicates();
    test_width_saturation();
    test_random_runs();
    wait_idle();
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
src/glm_pkg.sv
src/glm_datapath.sv
src/glm_ctrl.sv
src/glyph_lookup_text_measure_top.sv
src/glm_checker.sv
tb/tb.sv
